FILE: hdl/lsp_pkg.sv
`default_nettype none

package lsp_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_TOP    = 3'd3,
    CMD_BOTTOM = 3'd4
  } command_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  // what every cell does on a transfer
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } shift_op_t;

  typedef struct packed {
    shift_op_t op;
    status_t   status;
    logic      use_data;
    logic      full;
    logic      empty;
  } ctrl_t;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

endpackage

`default_nettype wire

FILE: hdl/lsp_cell.sv
`default_nettype none

module lsp_cell
  import lsp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire shift_op_t        op,
  input  wire logic [WIDTH-1:0] above,
  input  wire logic [WIDTH-1:0] below,
  output logic      [WIDTH-1:0] word
);

  logic [WIDTH-1:0] word_next;

  always_comb begin
    unique case (op)
      OP_PUSH: word_next = above;
      OP_POP:  word_next = below;
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

FILE: hdl/lsp_ctrl.sv
`default_nettype none

module lsp_ctrl
  import lsp_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic [2:0]                     command,
  input  wire logic [4:0]                     position,
  input  wire logic [$clog2(DEPTH+1)-1:0]     entry_count,
  input  wire logic [4:0]                     limit,
  output ctrl_t                               ctrl,
  output logic      [$clog2(DEPTH)-1:0]       rd_idx,
  output logic      [$clog2(DEPTH+1)-1:0]     count_next
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = (CW > 5) ? CW : 5;

  logic [XW-1:0] lim_x;
  logic [XW-1:0] depth_x;
  logic [XW-1:0] lim_eff;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_next_x;

  // limit of zero acts as one, anything above DEPTH as DEPTH
  always_comb begin
    lim_x   = XW'(limit);
    depth_x = XW'(DEPTH);
    priority if (lim_x == '0) begin
      lim_eff = XW'(1);
    end else if (lim_x > depth_x) begin
      lim_eff = depth_x;
    end else begin
      lim_eff = lim_x;
    end
  end

  // top of stack sits in cell 0
  always_comb begin
    cnt_x         = XW'(entry_count);
    pos_x         = XW'(position);
    ctrl.op       = OP_HOLD;
    ctrl.status   = ST_OK;
    ctrl.use_data = 1'b0;
    rd_idx        = '0;
    count_next    = entry_count;
    unique case (command)
      CMD_PUSH: begin
        if (cnt_x >= lim_eff) begin
          ctrl.status = ST_FULL;
        end else begin
          ctrl.op    = OP_PUSH;
          count_next = entry_count + CW'(1);
        end
      end
      CMD_POP: begin
        if (entry_count == '0) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.op       = OP_POP;
          ctrl.use_data = 1'b1;
          count_next    = entry_count - CW'(1);
        end
      end
      CMD_PEEK: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          ctrl.status = ST_BAD_POS;
        end else begin
          ctrl.use_data = 1'b1;
          rd_idx        = IW'(pos_x - XW'(1));
        end
      end
      CMD_TOP: begin
        if (entry_count == '0) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.use_data = 1'b1;
        end
      end
      CMD_BOTTOM: begin
        if (entry_count == '0) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.use_data = 1'b1;
          rd_idx        = IW'(entry_count - CW'(1));
        end
      end
      default: ;
    endcase
    cnt_next_x = XW'(count_next);
    ctrl.full  = (cnt_next_x >= lim_eff);
    ctrl.empty = (count_next == '0);
  end

endmodule

`default_nettype wire

FILE: hdl/lifo_stack_with_peek.sv
`default_nettype none

// Bounded LIFO stack of words with peek. Every command transfer (push, pop,
// peek at depth n from the top, read top, read bottom) yields one result with
// data, status, entry count and full/empty flags. A command is taken every
// clock: the result is registered and appears on the cycle after the
// transfer, and in_ready only drops while that output register holds a
// result the consumer has not taken. The entries live in a row of DEPTH
// cells with the top in the first cell; a push shifts the whole row down one
// cell and a pop shifts it up, so each command costs one cell update plus
// one read through the cell select. stack_limit (0 acts as 1, above DEPTH as
// DEPTH) may be written only while no result is pending.
module lifo_stack_with_peek
  import lsp_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               stack_limit_wen,
  input  wire logic [4:0]         stack_limit,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         command,
  input  wire logic signed [31:0] value,
  input  wire logic [4:0]         position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      data,
  output logic [1:0]              status,
  output logic [4:0]              count,
  output logic                    is_full,
  output logic                    is_empty
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [4:0]           limit;
  logic [CW-1:0]        entry_count;
  logic [CW-1:0]        entry_count_next;
  ctrl_t                ctrl;
  logic [IW-1:0]        rd_idx;
  logic                 accept;
  shift_op_t            cell_op;
  logic [WORD_BITS-1:0] push_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] cell_word  [DEPTH];
  logic [WORD_BITS-1:0] above_word [DEPTH];
  logic [WORD_BITS-1:0] below_word [DEPTH];

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cell_op   = accept ? ctrl.op : OP_HOLD;
  assign push_word = WORD_BITS'($unsigned(value));
  assign rd_word   = cell_word[rd_idx];

  lsp_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .command    (command),
    .position   (position),
    .entry_count(entry_count),
    .limit      (limit),
    .ctrl       (ctrl),
    .rd_idx     (rd_idx),
    .count_next (entry_count_next)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      assign above_word[i] = push_word;
    end else begin : g_mid
      assign above_word[i] = cell_word[i-1];
    end
    // the last cell's contents past the count are never read
    if (i == DEPTH - 1) begin : g_last
      assign below_word[i] = cell_word[i];
    end else begin : g_inner
      assign below_word[i] = cell_word[i+1];
    end

    lsp_cell #(
      .WIDTH(WORD_BITS)
    ) u_cell (
      .clk  (clk),
      .op   (cell_op),
      .above(above_word[i]),
      .below(below_word[i]),
      .word (cell_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit       <= LIMIT_RESET;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (stack_limit_wen) begin
        limit <= stack_limit;
      end
      if (accept) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      data     <= ctrl.use_data ? 32'(rd_word) : '0;
      status   <= ctrl.status;
      count    <= 5'(entry_count_next);
      is_full  <= ctrl.full;
      is_empty <= ctrl.empty;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_push_incr: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.op == OP_PUSH) |=> entry_count == CW'($past(entry_count) + CW'(1)))
    else $error("push did not grow the stack");

  a_pop_decr: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.op == OP_POP) |=> entry_count == CW'($past(entry_count) - CW'(1)))
    else $error("pop did not shrink the stack");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> data == '0)
    else $error("error result carries data");

endmodule

`default_nettype wire
